[sv/ipv4p_pkg.sv]
// shared types and character codes for the ipv4 dotted text parser
package ipv4p_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // one finished parse
  typedef struct packed {
    logic        address_ok;
    logic [31:0] address;
  } result_t;

  // handoff from the scanner to the result register
  typedef struct packed {
    logic    emit;
    result_t res;
  } step_t;

endpackage

[sv/ipv4p_if.sv]
// handshake interfaces for the character and result channels
interface ipv4p_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface ipv4p_result_if;
  logic        valid;
  logic        ready;
  logic        address_ok;
  logic [31:0] address;

  modport source (output valid, output address_ok, output address, input ready);
  modport sink (input valid, input address_ok, input address, output ready);
endinterface

[sv/ipv4_dotted_text_parser.sv]
// top level of the streaming ipv4 dotted text parser
// Takes one ASCII character per transfer and parses IPv4 text in the classic
// inet_aton style: one to four dot-separated parts, each decimal, octal after a
// leading zero (8 and 9 still accepted) or hex after 0x/0X, with each part
// wrapping modulo 2^32. NUL or whitespace ends the address; the last part fills
// the remaining bits and every earlier part must fit in a byte. One result
// transfer is produced per string, carrying address_ok and the host-order
// address (first part in the top byte, zero on failure), either at the
// terminator or at the first bad character; after any result except one at NUL
// the characters up to and including the next NUL are swallowed. Throughput is
// one character per cycle while the result side is not stalled, set by the
// combinational scanner step between the input register and the result register.
// The scanner only holds while the result register is full and the sink is not
// taking it; a character already in the input register then waits there, and an
// empty input register takes just one more character before the input side
// stalls as well.
module ipv4_dotted_text_parser (
  input  logic           clk,
  input  logic           rst,
  ipv4p_char_if.sink     char_in,
  ipv4p_result_if.source result
);
  import ipv4p_pkg::*;

  logic       advance;
  logic       held_valid;
  logic [7:0] held_char;
  step_t      step;
  result_t    res_out;

  // input register: skid stage ahead of the scanner
  ipv4p_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (char_in.valid),
    .in_char    (char_in.char_code),
    .in_ready   (char_in.ready),
    .advance    (advance),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  // scanner state steps once per held character when the result side is free
  ipv4p_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step_en   (held_valid && advance),
    .char_code (held_char),
    .step      (step)
  );

  // result register feeding the output channel
  ipv4p_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid && step.emit),
    .res_in    (step.res),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .res_out   (res_out),
    .advance   (advance)
  );

  assign result.address_ok = res_out.address_ok;
  assign result.address    = res_out.address;

endmodule

[sv/ipv4p_in_reg.sv]
// input register holding one character ahead of the scanner
module ipv4p_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_char,
  output logic       in_ready,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_char
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_char <= in_char;
    end
  end

endmodule

[sv/ipv4p_scan.sv]
// parser state and the per-character step
module ipv4p_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  logic [7:0]         char_code,
  output ipv4p_pkg::step_t   step
);
  import ipv4p_pkg::*;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [1:0]  base, base_next;
  logic [31:0] part_value, part_value_next;
  logic [1:0]  parts_seen, parts_seen_next;
  logic [31:0] earlier_parts [3];
  logic        store_part;

  logic        is_digit, is_space, is_hex_letter, is_end;
  logic [3:0]  nibble;
  logic [31:0] acc_dec, acc_oct, acc_hex, acc;
  logic        fin_ok;
  logic [31:0] fin_addr;

  assign is_digit      = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_space      = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign is_hex_letter = ((char_code >= CH_LO_A) && (char_code <= CH_LO_F))
                      || ((char_code >= CH_UP_A) && (char_code <= CH_UP_F));
  assign is_end        = (char_code == CH_NUL) || is_space;

  // letters a to f have low nibble 1 to 6, so adding 9 gives 10 to 15
  assign nibble  = is_digit ? char_code[3:0] : char_code[3:0] + 4'd9;
  assign acc_dec = (part_value << 3) + (part_value << 1) + {28'd0, nibble};
  assign acc_oct = (part_value << 3) + {28'd0, nibble};
  assign acc_hex = {part_value[27:0], nibble};

  always_comb begin
    case (base)
      BASE_HEX: acc = acc_hex;
      BASE_OCT: acc = acc_oct;
      default:  acc = acc_dec;
    endcase
  end

  // range checks and packing for the terminator
  always_comb begin
    unique case (parts_seen)
      2'd0: begin
        fin_ok   = 1'b1;
        fin_addr = part_value;
      end
      2'd1: begin
        fin_ok   = (part_value[31:24] == 8'd0) && (earlier_parts[0][31:8] == 24'd0);
        fin_addr = part_value | {earlier_parts[0][7:0], 24'd0};
      end
      2'd2: begin
        fin_ok   = (part_value[31:16] == 16'd0) && (earlier_parts[0][31:8] == 24'd0)
                && (earlier_parts[1][31:8] == 24'd0);
        fin_addr = part_value | {earlier_parts[0][7:0], earlier_parts[1][7:0], 16'd0};
      end
      default: begin
        fin_ok   = (part_value[31:8] == 24'd0) && (earlier_parts[0][31:8] == 24'd0)
                && (earlier_parts[1][31:8] == 24'd0) && (earlier_parts[2][31:8] == 24'd0);
        fin_addr = part_value | {earlier_parts[0][7:0], earlier_parts[1][7:0],
                                 earlier_parts[2][7:0], 8'd0};
      end
    endcase
  end

  always_comb begin
    phase_next      = phase;
    base_next       = base;
    part_value_next = part_value;
    parts_seen_next = parts_seen;
    store_part      = 1'b0;
    step.emit       = 1'b0;
    step.res        = '0;

    unique case (phase)
      PH_START: begin
        if (!is_digit) begin
          step.emit = 1'b1;
        end else if (char_code == CH_ZERO) begin
          part_value_next = 32'd0;
          base_next       = BASE_OCT;
          phase_next      = PH_ZERO;
        end else begin
          part_value_next = {28'd0, nibble};
          base_next       = BASE_DEC;
          phase_next      = PH_DIGITS;
        end
      end
      PH_ZERO, PH_DIGITS: begin
        if (phase == PH_ZERO && (char_code == CH_LO_X || char_code == CH_UP_X)) begin
          base_next  = BASE_HEX;
          phase_next = PH_DIGITS;
        end else if (is_digit || (base == BASE_HEX && is_hex_letter)) begin
          part_value_next = acc;
          phase_next      = PH_DIGITS;
        end else if (char_code == CH_DOT) begin
          if (parts_seen == 2'd3) begin
            step.emit = 1'b1;
          end else begin
            store_part      = 1'b1;
            parts_seen_next = parts_seen + 2'd1;
            part_value_next = 32'd0;
            base_next       = BASE_DEC;
            phase_next      = PH_START;
          end
        end else if (is_end) begin
          step.emit           = 1'b1;
          step.res.address_ok = fin_ok;
          step.res.address    = fin_ok ? fin_addr : 32'd0;
        end else begin
          step.emit = 1'b1;
        end
      end
      default: begin
        if (char_code == CH_NUL) begin
          phase_next = PH_START;
        end
      end
    endcase

    // any result re-arms; anything but nul then discards through the next nul
    if (step.emit) begin
      phase_next      = (char_code == CH_NUL) ? PH_START : PH_SKIP;
      base_next       = BASE_DEC;
      part_value_next = 32'd0;
      parts_seen_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      base       <= BASE_DEC;
      part_value <= 32'd0;
      parts_seen <= 2'd0;
    end else if (step_en) begin
      phase      <= phase_next;
      base       <= base_next;
      part_value <= part_value_next;
      parts_seen <= parts_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && store_part) begin
      earlier_parts[parts_seen] <= part_value;
    end
  end

  a_fail_then_skip: assert property (@(posedge clk) disable iff (rst)
    step_en && step.emit && char_code != CH_NUL |=> phase == PH_SKIP)
    else $error("result at a non-nul character did not enter discard");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    step_en && phase == PH_SKIP |-> !step.emit)
    else $error("result produced while discarding");

  a_digit_start_silent: assert property (@(posedge clk) disable iff (rst)
    step_en && phase == PH_START && is_digit |=> phase != PH_START && phase != PH_SKIP)
    else $error("digit at part start did not open a part");

  a_dot_counts: assert property (@(posedge clk) disable iff (rst)
    step_en && store_part |=> parts_seen == $past(parts_seen) + 2'd1)
    else $error("part count did not advance on a dot");

endmodule

[sv/ipv4p_out_reg.sv]
// result register between the scanner and the result channel
module ipv4p_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ipv4p_pkg::result_t res_in,
  input  logic               out_ready,
  output logic               out_valid,
  output ipv4p_pkg::result_t res_out,
  output logic               advance
);
  import ipv4p_pkg::*;

  // free when empty or being drained this cycle
  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      res_out <= res_in;
    end
  end

endmodule

[tb/sv/tb_ipv4_dotted_text_parser.sv]
// self-checking testbench for the streaming ipv4 dotted text parser
`timescale 1ns / 100ps

module tb_ipv4_dotted_text_parser;
  import ipv4p_pkg::*;

  typedef logic [7:0] char_t;

  // scan phases and number bases of the parse, as the block's own state moves
  typedef enum logic [2:0] {SCAN_START, SCAN_ZERO, SCAN_DIGITS, SCAN_SKIP} scan_e;
  typedef enum logic [1:0] {BASE_DEC, BASE_OCT, BASE_HEX} base_e;

  // tracks the parse of the character stream and holds the addresses still to come
  class addr_scoreboard;
    scan_e       phase;
    base_e       base;
    logic [31:0] part_val;
    logic [31:0] dotted [3];
    logic [1:0]  dots_seen;
    result_t     awaited [$];
    int unsigned fails;
    int unsigned ok_count;
    int unsigned bad_count;

    function new();
      rearm();
      dotted[0] = '0;
      dotted[1] = '0;
      dotted[2] = '0;
      fails = 0;
      ok_count = 0;
      bad_count = 0;
    endfunction

    function void rearm();
      phase = SCAN_START;
      base = BASE_DEC;
      part_val = '0;
      dots_seen = '0;
    endfunction

    function bit is_dec(char_t c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // one result per string; anything but a NUL leaves the rest of the string to skip
    function void post_result(bit ok, logic [31:0] addr, char_t c);
      result_t r;
      r.address_ok = ok;
      r.address = ok ? addr : 32'h0;
      awaited.push_back(r);
      if (ok) begin
        ok_count++;
      end else begin
        bad_count++;
      end
      rearm();
      if (c != CH_NUL) begin
        phase = SCAN_SKIP;
      end
    endfunction

    // the last part fills whatever the dotted parts leave, earlier parts are bytes
    function void close_address(char_t c);
      logic [31:0] v;
      v = part_val;
      case (dots_seen)
        2'd0: begin
          post_result(1'b1, v, c);
        end
        2'd1: begin
          if (v > 32'h00ffffff || dotted[0] > 32'hff) begin
            post_result(1'b0, 32'h0, c);
          end else begin
            post_result(1'b1, v | (dotted[0] << 24), c);
          end
        end
        2'd2: begin
          if (v > 32'h0000ffff || dotted[0] > 32'hff || dotted[1] > 32'hff) begin
            post_result(1'b0, 32'h0, c);
          end else begin
            post_result(1'b1, v | (dotted[0] << 24) | (dotted[1] << 16), c);
          end
        end
        default: begin
          if (v > 32'hff || dotted[0] > 32'hff || dotted[1] > 32'hff
              || dotted[2] > 32'hff) begin
            post_result(1'b0, 32'h0, c);
          end else begin
            post_result(1'b1, v | (dotted[0] << 24) | (dotted[1] << 16) | (dotted[2] << 8), c);
          end
        end
      endcase
    endfunction

    function void after_digits(char_t c);
      logic [31:0] d;
      bit          hex_letter;
      hex_letter = 1'b0;
      d = '0;
      if (c >= CH_LO_A && c <= CH_LO_F) begin
        hex_letter = 1'b1;
        d = 32'(c - CH_LO_A) + 32'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
        hex_letter = 1'b1;
        d = 32'(c - CH_UP_A) + 32'd10;
      end
      if (is_dec(c)) begin
        d = 32'(c - CH_ZERO);
        if (base == BASE_HEX) begin
          part_val = (part_val << 4) | d;
        end else if (base == BASE_OCT) begin
          part_val = part_val * 32'd8 + d;
        end else begin
          part_val = part_val * 32'd10 + d;
        end
        phase = SCAN_DIGITS;
      end else if (base == BASE_HEX && hex_letter) begin
        part_val = (part_val << 4) | d;
        phase = SCAN_DIGITS;
      end else if (c == CH_DOT) begin
        if (dots_seen == 2'd3) begin
          post_result(1'b0, 32'h0, c);
        end else begin
          dotted[dots_seen] = part_val;
          dots_seen++;
          part_val = '0;
          base = BASE_DEC;
          phase = SCAN_START;
        end
      end else if (c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        close_address(c);
      end else begin
        post_result(1'b0, 32'h0, c);
      end
    endfunction

    // called for every character transfer accepted by the block
    function void note_char(char_t c);
      case (phase)
        SCAN_START: begin
          if (!is_dec(c)) begin
            post_result(1'b0, 32'h0, c);
          end else if (c == CH_ZERO) begin
            part_val = '0;
            phase = SCAN_ZERO;
            base = BASE_OCT;
          end else begin
            base = BASE_DEC;
            part_val = 32'(c - CH_ZERO);
            phase = SCAN_DIGITS;
          end
        end
        SCAN_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            base = BASE_HEX;
            phase = SCAN_DIGITS;
          end else begin
            after_digits(c);
          end
        end
        SCAN_DIGITS: begin
          after_digits(c);
        end
        default: begin
          if (c == CH_NUL) begin
            rearm();
          end
        end
      endcase
    endfunction

    // called for every result transfer taken from the block
    function void check_result(logic ok, logic [31:0] addr);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with none awaited: address_ok=%0b address=%08h",
                 $time, ok, addr);
        fails++;
      end else begin
        want = awaited.pop_front();
        if (ok !== want.address_ok) begin
          $display("%0t: address_ok wrong: expected %0b actual %0b",
                   $time, want.address_ok, ok);
          fails++;
        end
        if (addr !== want.address) begin
          $display("%0t: address wrong: expected %08h actual %08h",
                   $time, want.address, addr);
          fails++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ipv4p_char_if   char_if ();
  ipv4p_result_if res_if ();

  ipv4_dotted_text_parser DUT (
    .clk    (clk),
    .rst    (rst),
    .char_in(char_if),
    .result (res_if)
  );

  addr_scoreboard sb;
  char_t          line_chars [$];
  int unsigned    chars_sent;
  int unsigned    lines_sent;
  bit             quiet_tail;
  bit             sender_bursty;
  int             rx_stall_left;
  int             rx_odds;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result sink: ready changes on the falling edge and drops in bursts of stalled cycles;
  // the stall odds wander so that some stretches have no back-pressure at all
  always @(negedge clk) begin
    if ($urandom_range(0, 149) == 0) begin
      case ($urandom_range(0, 2))
        0: rx_odds = 0;
        1: rx_odds = 3;
        default: rx_odds = 12;
      endcase
    end
    if (rx_stall_left > 0) begin
      res_if.ready <= 1'b0;
      rx_stall_left--;
    end else if (!quiet_tail && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
      res_if.ready <= 1'b0;
      rx_stall_left = $urandom_range(0, 17);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // every result transfer is checked at the rising edge where it happens
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      sb.check_result(res_if.address_ok, res_if.address);
    end
  end

  // one character transfer; valid is only ever changed on the falling edge,
  // with an optional idle gap ahead of the character
  task automatic send_char(input char_t c);
    int gap;
    gap = 0;
    if (!quiet_tail && sender_bursty && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
    end
    @(negedge clk);
    if (gap != 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_if.valid <= 1'b1;
    char_if.char_code <= c;
    do @(posedge clk); while (!char_if.ready);
    sb.note_char(c);
    chars_sent++;
  endtask

  task automatic send_line();
    char_t c;
    while (line_chars.size() != 0) begin
      c = line_chars.pop_front();
      send_char(c);
    end
    lines_sent++;
  endtask

  // hold the sender off until every awaited address has come out
  task automatic wait_drained();
    @(negedge clk);
    char_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_chars.push_back(char_t'(s[i]));
    end
  endtask

  function automatic char_t digit_char(logic [31:0] d, bit upper);
    if (d < 32'd10) begin
      return CH_ZERO + d[7:0];
    end
    return (upper ? CH_UP_A : CH_LO_A) + d[7:0] - 8'd10;
  endfunction

  // a value in the given radix with its prefix; octal text sometimes gets an 8 or 9,
  // and a hex zero is sometimes written as a bare 0x
  task automatic push_value(input logic [31:0] v, input int unsigned radix);
    char_t digs [$];
    bit    no_digits;
    no_digits = 1'b0;
    if (radix == 16) begin
      line_chars.push_back(CH_ZERO);
      line_chars.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LO_X);
      no_digits = (v == 0) && $urandom_range(0, 1);
    end else if (radix == 8) begin
      line_chars.push_back(CH_ZERO);
      no_digits = (v == 0);
    end
    if (!no_digits) begin
      do begin
        digs.push_front(digit_char(v % radix, $urandom_range(0, 1) == 1));
        v = v / radix;
      end while (v != 0);
      if (radix == 8 && $urandom_range(0, 5) == 0) begin
        digs[$urandom_range(0, digs.size() - 1)] = CH_NINE - char_t'($urandom_range(0, 1));
      end
    end
    while (digs.size() != 0) line_chars.push_back(digs.pop_front());
  endtask

  // one to four parts (now and then five), values around the limits of each part
  task automatic build_address_text();
    int          n;
    int          pick;
    int          len;
    int unsigned radix;
    logic [31:0] lim;
    logic [31:0] v;
    n = $urandom_range(1, 4);
    if ($urandom_range(0, 19) == 0) begin
      n = 5;
    end
    for (int i = 0; i < n; i++) begin
      if (i < n - 1 || n > 4) begin
        lim = 32'hff;
      end else begin
        lim = 32'hffffffff >> (8 * (n - 1));
      end
      pick = $urandom_range(0, 9);
      radix = (pick < 5) ? 10 : 16;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) begin
        radix = 8;
      end
      case (pick)
        0: v = '0;
        1: v = lim;
        2: v = lim + 32'd1;
        default: v = $urandom_range(lim, 0);
      endcase
      if (pick == 3) begin
        // long digit run, so the part wraps past 32 bits
        if (radix == 16) begin
          line_chars.push_back(CH_ZERO);
          line_chars.push_back(CH_LO_X);
          len = $urandom_range(9, 12);
        end else if (radix == 8) begin
          line_chars.push_back(CH_ZERO);
          len = $urandom_range(11, 14);
        end else begin
          line_chars.push_back(digit_char($urandom_range(1, 9), 1'b0));
          len = $urandom_range(10, 13);
        end
        repeat (len) begin
          line_chars.push_back(digit_char($urandom_range(0, radix == 16 ? 15 : 9),
                                          $urandom_range(0, 1) == 1));
        end
      end else begin
        push_value(v, radix);
      end
      if (i < n - 1) begin
        line_chars.push_back(CH_DOT);
      end
    end
  endtask

  // NUL most of the time; otherwise whitespace, some junk that is skipped, then NUL
  task automatic push_ending();
    int sel;
    if ($urandom_range(0, 9) < 6) begin
      line_chars.push_back(CH_NUL);
    end else begin
      sel = $urandom_range(0, 5);
      line_chars.push_back(sel == 0 ? CH_SPACE : CH_TAB + char_t'(sel - 1));
      repeat ($urandom_range(0, 4)) line_chars.push_back(char_t'($urandom_range(1, 255)));
      line_chars.push_back(CH_NUL);
    end
  endtask

  initial begin
    bit paused_once;
    int kind;
    int guard;
    rst = 1'b1;
    char_if.valid = 1'b0;
    char_if.char_code = CH_NUL;
    res_if.ready = 1'b0;
    quiet_tail = 1'b0;
    sender_bursty = 1'b1;
    rx_stall_left = 0;
    rx_odds = 4;
    chars_sent = 0;
    lines_sent = 0;
    paused_once = 1'b0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty string
    line_chars.push_back(CH_NUL);
    send_line();
    // top code as the first character, then skipped through NUL
    line_chars.push_back(8'hff);
    line_chars.push_back(CH_NUL);
    send_line();
    // 0X with no hex digits, ended by a tab
    push_str("0X");
    line_chars.push_back(CH_TAB);
    line_chars.push_back(CH_NUL);
    send_line();
    // string ending straight after a dot
    push_str("9.");
    line_chars.push_back(CH_NUL);
    send_line();
    // fourth dot
    push_str("0.0.0.0.");
    line_chars.push_back(CH_NUL);
    send_line();
    // earlier part over a byte
    push_str("256.0");
    line_chars.push_back(CH_NUL);
    send_line();
    // octal with a 9
    push_str("09");
    line_chars.push_back(CH_NUL);
    send_line();
    // stray letter after the digits
    push_str("7g");
    line_chars.push_back(CH_NUL);
    send_line();
    wait_drained();

    // random: mostly well-formed addresses, some corrupted, some plain noise
    while (chars_sent < 1150) begin
      if (!paused_once && chars_sent > 600) begin
        wait_drained();
        paused_once = 1'b1;
      end
      quiet_tail = (chars_sent > 1000);
      sender_bursty = ($urandom_range(0, 9) < 7);
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        build_address_text();
        push_ending();
      end else if (kind < 17) begin
        build_address_text();
        push_ending();
        line_chars[$urandom_range(0, line_chars.size() - 2)] =
          $urandom_range(0, 1) ? CH_DOT : char_t'($urandom_range(0, 255));
      end else begin
        repeat ($urandom_range(1, 8)) line_chars.push_back(char_t'($urandom_range(0, 255)));
        line_chars.push_back(CH_NUL);
      end
      send_line();
    end
    @(negedge clk);
    char_if.valid <= 1'b0;

    // let the last addresses out, then keep watching for anything unexpected
    guard = 0;
    while (sb.awaited.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.awaited.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.awaited.size());
      $display("ipv4_dotted_text_parser: mismatch");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      $display("%0d characters in %0d strings sent, %0d valid and %0d rejected addresses",
               chars_sent, lines_sent, sb.ok_count, sb.bad_count);
      $display("covered decimal, octal and hex parts, wrapping runs and whitespace endings");
      if (sb.fails == 0) begin
        $display("ipv4_dotted_text_parser: match");
      end else begin
        $display("ipv4_dotted_text_parser: mismatch");
      end
      $finish;
    end
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("ipv4_dotted_text_parser: mismatch");
    $finish;
  end

endmodule

[sim.f]
sv/ipv4p_pkg.sv
sv/ipv4p_if.sv
sv/ipv4p_in_reg.sv
sv/ipv4p_scan.sv
sv/ipv4p_out_reg.sv
sv/ipv4_dotted_text_parser.sv
tb/sv/tb_ipv4_dotted_text_parser.sv
